/* src/cjt_pkg.sv */
package cjt_pkg;

  // table geometry and field widths
  localparam int DEPTH           = 32;
  localparam int KEY_W           = 16;
  localparam int LEN_W           = 16;
  localparam int SEQ_W           = 32;
  localparam int REQ_W           = 3;
  localparam int SHORT_WINDOW    = 65536;
  localparam int SSEQ_W          = $clog2(SHORT_WINDOW);
  localparam int LOWER_MARGIN    = 256;
  localparam int CLEAN_THRESHOLD = 16384;
  localparam int MAX_RESULTS     = 32;
  localparam int WALK_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HIT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [SEQ_W-1:0] SAFE_SPAN  = SEQ_W'(SHORT_WINDOW - LOWER_MARGIN);
  localparam logic [SEQ_W-1:0] WINDOW_SEQ = SEQ_W'(SHORT_WINDOW);
  localparam logic [SEQ_W-1:0] MARGIN2    = SEQ_W'(2 * LOWER_MARGIN);
  localparam logic [SEQ_W-1:0] CLEAN_SEQ  = SEQ_W'(CLEAN_THRESHOLD);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD  = 3'd0,
    REQ_BUMP    = 3'd1,
    REQ_HASKEY  = 3'd2,
    REQ_HASANY  = 3'd3,
    REQ_ITERATE = 3'd4,
    REQ_CLEAN   = 3'd5
  } req_t;

  // one journal entry as held in a cell
  typedef struct packed {
    logic              occ;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [SSEQ_W-1:0] sseq;
  } entry_t;

  // per-cycle command to the cell row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_RECORD,
    CMD_ROTATE,
    CMD_MARK,
    CMD_COMPACT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [SSEQ_W-1:0] sseq;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  thr;
    logic              match_any;
    logic              ins_en;
  } cell_ctl_t;

  typedef struct packed {
    logic qual;
    logic match;
  } cell_stat_t;

  // summary of the whole row
  typedef struct packed {
    logic match_any;
    logic key_hit;
    logic any_hit;
    logic full;
    logic packed_ok;
  } row_stat_t;

  // widen a short sequence number against the running counter
  function automatic logic [SEQ_W-1:0] long_of(input logic [SEQ_W-1:0] seq,
                                               input logic [SSEQ_W-1:0] s);
    logic [SSEQ_W-1:0] d;
    d = seq[SSEQ_W-1:0] - s;
    return seq - SEQ_W'(d);
  endfunction

endpackage

/* src/cjt_cell.sv */
module cjt_cell (
  input  logic                clk,
  input  logic                rst,
  input  cjt_pkg::cell_ctl_t  ctl,
  input  cjt_pkg::entry_t     prev,
  input  cjt_pkg::entry_t     next,
  input  logic                hole_in,
  output cjt_pkg::entry_t     ent,
  output cjt_pkg::cell_stat_t stat,
  output logic                hole_out
);

  cjt_pkg::entry_t ent_next;
  logic            prev_gt;
  logic            self_gt;

  // compares against the request
  assign stat.match = ent.occ && (ent.key == ctl.key);
  assign stat.qual  = ent.occ && (cjt_pkg::long_of(ctl.seq, ent.sseq) >= ctl.thr);
  assign prev_gt    = prev.occ && (prev.key > ctl.key);
  assign self_gt    = !ent.occ || (ent.key > ctl.key);
  assign hole_out   = hole_in | !ent.occ;

  // next contents of this cell
  always_comb begin
    ent_next = ent;
    case (ctl.cmd)
      cjt_pkg::CMD_RECORD: begin
        if (ctl.match_any) begin
          if (stat.match) begin
            ent_next.len  = ctl.len;
            ent_next.sseq = ctl.sseq;
          end
        end else if (ctl.ins_en) begin
          if (prev_gt) begin
            ent_next = prev;
          end else if (self_gt && !hole_in) begin
            // only the first slot past the smaller keys takes the new entry
            ent_next.occ  = 1'b1;
            ent_next.key  = ctl.key;
            ent_next.len  = ctl.len;
            ent_next.sseq = ctl.sseq;
          end
        end
      end
      cjt_pkg::CMD_ROTATE: ent_next = next;
      cjt_pkg::CMD_MARK: ent_next.occ = stat.qual;
      cjt_pkg::CMD_COMPACT: begin
        if (hole_out) begin
          ent_next = next;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.occ <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

/* src/cjt_chain.sv */
module cjt_chain (
  input  logic               clk,
  input  logic               rst,
  input  cjt_pkg::cell_ctl_t ctl,
  input  cjt_pkg::entry_t    tail_in,
  output cjt_pkg::entry_t    head,
  output logic               head_qual,
  output cjt_pkg::row_stat_t row
);

  cjt_pkg::entry_t     ents  [cjt_pkg::DEPTH];
  cjt_pkg::cell_stat_t stats [cjt_pkg::DEPTH];
  logic [cjt_pkg::DEPTH-1:0] holes;
  logic [cjt_pkg::DEPTH-1:0] key_eq;
  logic [cjt_pkg::DEPTH-1:0] quals;
  logic [cjt_pkg::DEPTH-1:0] gaps;

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < cjt_pkg::DEPTH; i++) begin : g_cell
    cjt_pkg::entry_t prev_e;
    cjt_pkg::entry_t next_e;
    logic            hin;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign hin    = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign hin    = holes[i-1];
    end
    if (i == cjt_pkg::DEPTH - 1) begin : g_last
      assign next_e = tail_in;
      assign gaps[i] = 1'b0;
    end else begin : g_inner
      assign next_e  = ents[i+1];
      assign gaps[i] = holes[i] && ents[i+1].occ;
    end
    cjt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev     (prev_e),
      .next     (next_e),
      .hole_in  (hin),
      .ent      (ents[i]),
      .stat     (stats[i]),
      .hole_out (holes[i])
    );
    assign key_eq[i] = stats[i].match;
    assign quals[i]  = stats[i].qual;
  end

  // row summary
  assign head          = ents[0];
  assign head_qual     = quals[0];
  assign row.match_any = |key_eq;
  assign row.key_hit   = |(key_eq & quals);
  assign row.any_hit   = |quals;
  assign row.full      = ents[cjt_pkg::DEPTH-1].occ;
  assign row.packed_ok = ~|gaps;

endmodule

/* src/change_journal_table.sv */
// record, queries and plain bump post their result from the execute state once the output
// is free; bump with re-dating first rotates the cell row once to re-date its entries;
// iterate walks the row once, held by output stalls, one result per hit up to MAX_RESULTS,
// or a single empty result when nothing hits; clean marks, then compacts until packed.
// one item at a time; the next item is taken once the last result is posted.
// reset: table empty, counter 1, lower bound 0, nothing pending, no result held.
module change_journal_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cjt_pkg::REQ_W-1:0]     req_type,
  input  logic [cjt_pkg::KEY_W-1:0]     obj_key,
  input  logic [cjt_pkg::LEN_W-1:0]     obj_len,
  input  logic [cjt_pkg::SEQ_W-1:0]     since_seq,
  input  logic                          flag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          answer,
  output logic [cjt_pkg::KEY_W-1:0]     out_key,
  output logic [cjt_pkg::LEN_W-1:0]     out_len,
  output logic [cjt_pkg::SEQ_W-1:0]     cur_seq,
  output logic                          valid_key,
  output logic                          status,
  output logic                          last
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_REDATE, S_ITER, S_ITER_END, S_COMPACT, S_DONE
  } state_t;

  state_t                      state;
  cjt_pkg::req_t               r_req;
  logic [cjt_pkg::KEY_W-1:0]   r_key;
  logic [cjt_pkg::LEN_W-1:0]   r_len;
  logic [cjt_pkg::SEQ_W-1:0]   r_since;
  logic                        r_flag;
  logic [cjt_pkg::SEQ_W-1:0]   seq;
  logic [cjt_pkg::SEQ_W-1:0]   lb;
  logic [cjt_pkg::SEQ_W-1:0]   lb_tmp;
  logic [cjt_pkg::SEQ_W-1:0]   lowest;
  logic                        pending;
  logic [cjt_pkg::WALK_W-1:0]  walk;
  logic [cjt_pkg::HIT_W-1:0]   hits;
  logic                        pend_v;
  logic [cjt_pkg::KEY_W-1:0]   pend_key;
  logic [cjt_pkg::LEN_W-1:0]   pend_len;

  cjt_pkg::cell_ctl_t          ctl;
  cjt_pkg::entry_t             head;
  cjt_pkg::entry_t             redated;
  cjt_pkg::entry_t             tail_in;
  cjt_pkg::row_stat_t          row;
  logic                        head_qual;
  logic                        out_free;
  logic [cjt_pkg::SEQ_W-1:0]   seq_inc;
  logic [cjt_pkg::SEQ_W-1:0]   oldest;
  logic [cjt_pkg::SEQ_W-1:0]   head_long;
  logic                        head_old;
  logic [cjt_pkg::SEQ_W-1:0]   lowest_next;
  logic                        hit;
  logic                        iter_step;
  logic                        walk_end;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign seq_inc  = seq + 1'b1;
  assign oldest   = (r_since == '0) ? (seq - cjt_pkg::CLEAN_SEQ) : r_since;
  assign walk_end = (walk == cjt_pkg::WALK_W'(cjt_pkg::DEPTH - 1));

  // re-dating of the entry leaving the head of the row
  assign head_long = cjt_pkg::long_of(seq, head.sseq);
  assign head_old  = (seq - head_long) > cjt_pkg::SAFE_SPAN;
  always_comb begin
    redated     = head;
    lowest_next = lowest;
    if (head.occ) begin
      if (head_old) begin
        redated.sseq = lb_tmp[cjt_pkg::SSEQ_W-1:0];
        lowest_next  = lb_tmp;
      end else if (head_long < lowest) begin
        lowest_next = head_long;
      end
    end
  end

  // iterate walk
  assign hit       = head_qual && (hits < cjt_pkg::HIT_W'(cjt_pkg::MAX_RESULTS));
  assign iter_step = !(hit && pend_v) || out_free;

  always_comb begin
    case (state)
      S_COMPACT: tail_in = '0;
      S_REDATE:  tail_in = redated;
      default:   tail_in = head;
    endcase
  end

  // command to the cell row
  always_comb begin
    ctl.cmd       = cjt_pkg::CMD_HOLD;
    ctl.key       = r_key;
    ctl.len       = r_len;
    ctl.sseq      = seq[cjt_pkg::SSEQ_W-1:0];
    ctl.seq       = seq;
    ctl.thr       = r_since;
    ctl.match_any = row.match_any;
    ctl.ins_en    = r_flag && !row.full;
    case (state)
      S_EXEC: begin
        if (r_req == cjt_pkg::REQ_RECORD && out_free) begin
          ctl.cmd = cjt_pkg::CMD_RECORD;
        end else if (r_req == cjt_pkg::REQ_CLEAN) begin
          ctl.cmd = cjt_pkg::CMD_MARK;
          ctl.thr = oldest;
        end
      end
      S_REDATE: ctl.cmd = cjt_pkg::CMD_ROTATE;
      S_ITER: begin
        if (iter_step) begin
          ctl.cmd = cjt_pkg::CMD_ROTATE;
        end
      end
      S_COMPACT: begin
        if (!row.packed_ok) begin
          ctl.cmd = cjt_pkg::CMD_COMPACT;
        end
      end
      default: ctl.cmd = cjt_pkg::CMD_HOLD;
    endcase
  end

  cjt_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .tail_in   (tail_in),
    .head      (head),
    .head_qual (head_qual),
    .row       (row)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seq       <= cjt_pkg::SEQ_W'(1);
      lb        <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_req   <= cjt_pkg::req_t'(req_type);
            r_key   <= obj_key;
            r_len   <= obj_len;
            r_since <= since_seq;
            r_flag  <= flag;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (r_req == cjt_pkg::REQ_CLEAN) begin
            state <= S_COMPACT;
          end else if (r_req == cjt_pkg::REQ_ITERATE) begin
            walk   <= '0;
            hits   <= '0;
            pend_v <= 1'b0;
            state  <= S_ITER;
          end else if (out_free) begin
            out_valid <= 1'b1;
            answer    <= 1'b0;
            out_key   <= '0;
            out_len   <= '0;
            valid_key <= 1'b0;
            status    <= 1'b0;
            last      <= 1'b1;
            cur_seq   <= seq;
            state     <= S_IDLE;
            case (r_req)
              cjt_pkg::REQ_RECORD: begin
                pending <= 1'b1;
                status  <= !row.match_any && r_flag && row.full;
              end
              cjt_pkg::REQ_BUMP: begin
                if (r_flag || pending) begin
                  pending <= 1'b0;
                  seq     <= seq_inc;
                  cur_seq <= seq_inc;
                  if ((seq_inc - lb) > cjt_pkg::SAFE_SPAN) begin
                    out_valid <= 1'b0;
                    lb_tmp    <= seq_inc - cjt_pkg::WINDOW_SEQ + cjt_pkg::MARGIN2;
                    lowest    <= seq_inc;
                    walk      <= '0;
                    state     <= S_REDATE;
                  end
                end
              end
              cjt_pkg::REQ_HASKEY: answer <= row.key_hit;
              cjt_pkg::REQ_HASANY: answer <= row.any_hit;
              default: answer <= 1'b0;
            endcase
          end
        end
        S_REDATE: begin
          walk   <= walk + 1'b1;
          lowest <= lowest_next;
          if (walk_end) begin
            lb    <= lowest_next;
            state <= S_DONE;
          end
        end
        S_ITER: begin
          if (iter_step) begin
            walk <= walk + 1'b1;
            if (hit) begin
              hits     <= hits + 1'b1;
              pend_v   <= 1'b1;
              pend_key <= head.key;
              pend_len <= head.len;
              if (pend_v) begin
                out_valid <= 1'b1;
                answer    <= 1'b0;
                out_key   <= pend_key;
                out_len   <= pend_len;
                valid_key <= 1'b1;
                status    <= 1'b0;
                last      <= 1'b0;
                cur_seq   <= seq;
              end
            end
            if (walk_end) begin
              state <= S_ITER_END;
            end
          end
        end
        S_ITER_END: begin
          if (out_free) begin
            out_valid <= 1'b1;
            answer    <= 1'b0;
            out_key   <= pend_v ? pend_key : '0;
            out_len   <= pend_v ? pend_len : '0;
            valid_key <= pend_v;
            status    <= 1'b0;
            last      <= 1'b1;
            cur_seq   <= seq;
            pend_v    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_COMPACT: begin
          if (row.packed_ok) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            answer    <= 1'b0;
            out_key   <= '0;
            out_len   <= '0;
            valid_key <= 1'b0;
            status    <= 1'b0;
            last      <= 1'b1;
            cur_seq   <= seq;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  // request codes the block does not define
  localparam logic [cjt_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [cjt_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct {
    logic                       answer;
    logic [cjt_pkg::KEY_W-1:0]  key;
    logic [cjt_pkg::LEN_W-1:0]  len;
    logic [cjt_pkg::SEQ_W-1:0]  seq;
    logic                       valid_key;
    logic                       status;
    logic                       last;
  } journal_res_t;

  // journal shadow: keeps its own table and predicts each item's results
  class journal_board;
    logic [cjt_pkg::KEY_W-1:0]  keys[cjt_pkg::DEPTH];
    logic [cjt_pkg::LEN_W-1:0]  lens[cjt_pkg::DEPTH];
    logic [cjt_pkg::SSEQ_W-1:0] sseqs[cjt_pkg::DEPTH];
    int                         count;
    logic [cjt_pkg::SEQ_W-1:0]  seq;
    logic [cjt_pkg::SEQ_W-1:0]  lower;
    logic                       pending;
    journal_res_t               due_q[$];

    function new();
      count = 0;
      seq = 1;
      lower = 0;
      pending = 0;
    endfunction

    function logic [cjt_pkg::SEQ_W-1:0] widen(logic [cjt_pkg::SSEQ_W-1:0] s);
      logic [cjt_pkg::SSEQ_W-1:0] d;
      d = seq[cjt_pkg::SSEQ_W-1:0] - s;
      return seq - {16'd0, d};
    endfunction

    function void push(logic a, logic [cjt_pkg::KEY_W-1:0] k, logic [cjt_pkg::LEN_W-1:0] l,
                       logic v, logic st, logic la);
      journal_res_t r;
      r.answer = a; r.key = k; r.len = l; r.seq = seq;
      r.valid_key = v; r.status = st; r.last = la;
      due_q = {due_q, r};
    endfunction

    function void note_request(logic [cjt_pkg::REQ_W-1:0] rq, logic [cjt_pkg::KEY_W-1:0] k,
                               logic [cjt_pkg::LEN_W-1:0] l,
                               logic [cjt_pkg::SEQ_W-1:0] since, logic f);
      int idx, pos, w, n;
      logic ans, st;
      logic [cjt_pkg::SEQ_W-1:0] o, lowest, oldest;
      ans = 0;
      st = 0;
      idx = count;
      for (int i = 0; i < count; i++)
        if (keys[i] == k && idx == count) idx = i;
      case (rq)
        cjt_pkg::REQ_RECORD: begin
          pending = 1;
          if (idx < count) begin
            lens[idx] = l;
            sseqs[idx] = seq[cjt_pkg::SSEQ_W-1:0];
          end else if (f) begin
            if (count >= cjt_pkg::DEPTH) st = 1;
            else begin
              pos = 0;
              while (pos < count && keys[pos] < k) pos++;
              for (int i = count; i > pos; i--) begin
                keys[i] = keys[i-1]; lens[i] = lens[i-1]; sseqs[i] = sseqs[i-1];
              end
              keys[pos] = k; lens[pos] = l; sseqs[pos] = seq[cjt_pkg::SSEQ_W-1:0];
              count++;
            end
          end
        end
        cjt_pkg::REQ_BUMP: begin
          if (f || pending) begin
            pending = 0;
            seq = seq + 1;
            // re-date entries drifting out of the short window
            if (seq - lower > cjt_pkg::SAFE_SPAN) begin
              lower = seq - cjt_pkg::WINDOW_SEQ + cjt_pkg::MARGIN2;
              lowest = seq;
              for (int i = 0; i < count; i++) begin
                o = widen(sseqs[i]);
                if (seq - o > cjt_pkg::SAFE_SPAN) begin
                  sseqs[i] = lower[cjt_pkg::SSEQ_W-1:0];
                  lowest = lower;
                end else if (o < lowest) lowest = o;
              end
              lower = lowest;
            end
          end
        end
        cjt_pkg::REQ_HASKEY: ans = (idx < count) && (widen(sseqs[idx]) >= since);
        cjt_pkg::REQ_HASANY:
          for (int i = 0; i < count; i++)
            if (widen(sseqs[i]) >= since) ans = 1;
        cjt_pkg::REQ_ITERATE: begin
          n = 0;
          for (int i = 0; i < count; i++)
            if (widen(sseqs[i]) >= since && n < cjt_pkg::MAX_RESULTS) begin
              push(0, keys[i], lens[i], 1, 0, 0);
              n++;
            end
          if (n == 0) push(0, 0, 0, 0, 0, 1);
          else due_q[$].last = 1;
          return;
        end
        cjt_pkg::REQ_CLEAN: begin
          oldest = (since == 0) ? seq - cjt_pkg::CLEAN_SEQ : since;
          w = 0;
          for (int i = 0; i < count; i++)
            if (widen(sseqs[i]) >= oldest) begin
              keys[w] = keys[i]; lens[w] = lens[i]; sseqs[w] = sseqs[i];
              w++;
            end
          count = w;
        end
        default: ;
      endcase
      push(ans, 0, 0, 0, st, 1);
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(journal_res_t got);
      journal_res_t e;
      if (due_q.size() == 0) return "result with nothing expected";
      e = due_q.pop_front();
      if (got.answer !== e.answer || got.key !== e.key || got.len !== e.len ||
          got.seq !== e.seq || got.valid_key !== e.valid_key ||
          got.status !== e.status || got.last !== e.last)
        return $sformatf({"got a%0b k%h l%h s%h v%0b st%0b la%0b, ",
                          "want a%0b k%h l%h s%h v%0b st%0b la%0b"},
          got.answer, got.key, got.len, got.seq, got.valid_key, got.status, got.last,
          e.answer, e.key, e.len, e.seq, e.valid_key, e.status, e.last);
      return "";
    endfunction
  endclass

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic [cjt_pkg::REQ_W-1:0] req_type = '0;
  logic [cjt_pkg::KEY_W-1:0] obj_key = '0;
  logic [cjt_pkg::LEN_W-1:0] obj_len = '0;
  logic [cjt_pkg::SEQ_W-1:0] since_seq = '0;
  logic                      flag = 0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic                      answer;
  logic [cjt_pkg::KEY_W-1:0] out_key;
  logic [cjt_pkg::LEN_W-1:0] out_len;
  logic [cjt_pkg::SEQ_W-1:0] cur_seq;
  logic                      valid_key;
  logic                      status;
  logic                      last;

  journal_board sb = new();
  int           errors = 0;
  int           send_idle = 0;
  int           recv_stall = 0;

  change_journal_table u_top (.*);

  always #4 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // result side: check each accepted item, stall at random
  always @(posedge clk) begin
    journal_res_t got;
    string msg;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.answer = answer; got.key = out_key; got.len = out_len; got.seq = cur_seq;
        got.valid_key = valid_key; got.status = status; got.last = last;
        msg = sb.check_result(got);
        if (msg != "") report(msg);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // drive one request and wait until it is taken
  task automatic send_req(input logic [cjt_pkg::REQ_W-1:0] rq,
                          input logic [cjt_pkg::KEY_W-1:0] k,
                          input logic [cjt_pkg::LEN_W-1:0] l,
                          input logic [cjt_pkg::SEQ_W-1:0] since,
                          input logic f);
    req_type <= rq; obj_key <= k; obj_len <= l; since_seq <= since; flag <= f;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(rq, k, l, since, f);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [cjt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return cjt_pkg::KEY_W'($urandom);
    return cjt_pkg::KEY_W'($urandom_range(0, 47) * 1361);
  endfunction

  function automatic logic [cjt_pkg::SEQ_W-1:0] pick_since();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 0;
      default: return sb.seq - $urandom_range(0, 40);
    endcase
  endfunction

  task automatic rand_req();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) send_req(cjt_pkg::REQ_RECORD, pick_key(), cjt_pkg::LEN_W'($urandom),
                         $urandom, $urandom_range(0, 9) < 7);
    else if (w < 60) send_req(cjt_pkg::REQ_BUMP, pick_key(), cjt_pkg::LEN_W'($urandom),
                              $urandom, 1'($urandom_range(0, 1)));
    else if (w < 70) send_req(cjt_pkg::REQ_HASKEY, pick_key(), cjt_pkg::LEN_W'($urandom),
                              pick_since(), 1'($urandom_range(0, 1)));
    else if (w < 78) send_req(cjt_pkg::REQ_HASANY, pick_key(), cjt_pkg::LEN_W'($urandom),
                              pick_since(), 1'($urandom_range(0, 1)));
    else if (w < 88) send_req(cjt_pkg::REQ_ITERATE, pick_key(), cjt_pkg::LEN_W'($urandom),
                              pick_since(), 1'($urandom_range(0, 1)));
    else if (w < 96) send_req(cjt_pkg::REQ_CLEAN, pick_key(), cjt_pkg::LEN_W'($urandom),
                              $urandom_range(0, 1) ? 32'd0 : sb.seq - $urandom_range(0, 300),
                              1'($urandom_range(0, 1)));
    else send_req($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, pick_key(),
                  cjt_pkg::LEN_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, extremes, pending logic, full table, clean
    send_req(cjt_pkg::REQ_HASANY, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_ITERATE, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_HASKEY, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_RECORD, 16'h0000, 16'h0000, 0, 1);
    send_req(cjt_pkg::REQ_RECORD, 16'hffff, 16'hffff, 32'hffffffff, 1);
    send_req(cjt_pkg::REQ_RECORD, 16'hffff, 16'h1234, 0, 0);
    send_req(cjt_pkg::REQ_RECORD, 16'h5555, 16'h0001, 0, 0);
    send_req(cjt_pkg::REQ_BUMP, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_BUMP, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_BUMP, 16'hffff, 16'hffff, 32'hffffffff, 1);
    send_req(cjt_pkg::REQ_HASKEY, 16'h0000, 0, 0, 0);
    send_req(cjt_pkg::REQ_HASKEY, 16'hffff, 0, 32'hffffffff, 1);
    send_req(cjt_pkg::REQ_ITERATE, 0, 0, 0, 0);
    for (int i = 0; i < 32; i++)
      send_req(cjt_pkg::REQ_RECORD, cjt_pkg::KEY_W'($urandom),
               cjt_pkg::LEN_W'($urandom), 0, 1);
    send_req(cjt_pkg::REQ_RECORD, 16'h7777, 16'h0042, 0, 1);
    send_req(cjt_pkg::REQ_ITERATE, 0, 0, 0, 0);
    send_req(cjt_pkg::REQ_CLEAN, 0, 0, sb.seq, 0);
    send_req(cjt_pkg::REQ_CLEAN, 0, 0, 0, 0);
    send_req(REQ_SPARE_A, 16'h1111, 16'h2222, 32'h3333, 1);
    send_req(REQ_SPARE_B, 0, 0, 0, 0);

    // random part in idling phases
    for (int i = 0; i < 370; i++) begin
      case (i * 4 / 370)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 73; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 73; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      rand_req();
    end
    in_valid <= 0;

    guard = 0;
    while (sb.due_q.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (cjt_pkg::DEPTH + 10) @(posedge clk);
    if (sb.due_q.size() > 0) report($sformatf("%0d results never came", sb.due_q.size()));
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
src/cjt_pkg.sv
src/cjt_cell.sv
src/cjt_chain.sv
src/change_journal_table.sv
tb/sv/tb.sv
